@@ hw/rtl/fbbp_pkg.sv @@
// ----------------------------------------------------------------------------
// fbbp_pkg
// Shared types and constants of the fixed block buffer pool.
// ----------------------------------------------------------------------------
package fbbp_pkg;

    // operation selector carried in s_axis_tuser
    typedef enum logic [1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_FREE    = 2'd1,
        FUNC_REBUILD = 2'd2,
        FUNC_NOP     = 2'd3
    } t_func;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_BASE_ADDRESS  = 3'd0,
        CFG_BLOCK_COUNT   = 3'd1,
        CFG_BLOCK_SIZE    = 3'd2,
        CFG_HEADER_SIZE   = 3'd3,
        CFG_FIXED_RESERVE = 3'd4
    } t_cfg_idx;

    localparam int INDEX_SPAN = 256;
    localparam int MIN_BLOCKS = 2;

    localparam int IDX_W   = 8;
    localparam int EXTRA_W = 16;
    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 16;
    localparam int CNT_W   = 9;
    localparam int FAIL_W  = 32;
    localparam int CFG_W   = 32;

    localparam int S_TDATA_W = 24;   // block_index, extra_reserve
    localparam int S_TUSER_W = 2;    // func
    localparam int M_TDATA_W = 120;  // 115 bits of fields, zero padded
    localparam int M_TUSER_W = 1;    // ok

    // register reset values
    localparam logic [31:0] RST_BASE_ADDRESS  = 32'd0;
    localparam logic [8:0]  RST_BLOCK_COUNT   = 9'd256;
    localparam logic [15:0] RST_BLOCK_SIZE    = 16'd2048;
    localparam logic [7:0]  RST_HEADER_SIZE   = 8'd32;
    localparam logic [7:0]  RST_FIXED_RESERVE = 8'd6;

endpackage

@@ hw/rtl/fbbp_ram.sv @@
// ----------------------------------------------------------------------------
// fbbp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fbbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/fixed_block_buffer_pool.sv @@
// ----------------------------------------------------------------------------
// fixed_block_buffer_pool
// Receive-buffer pool of equal blocks with a LIFO free list.
// ----------------------------------------------------------------------------
// One operation per item on the slave stream: allocate, free or rebuild, each
// answered by one result on the master stream, through the input and output
// registers. Free, rebuild, failed and fresh-block allocates do not hold back
// the next item; an allocate that pops the free list does, while the link of
// the new list top is read from the link RAM, whose read port is registered.
// The link RAM needs no clearing pass: only entries written by a free are
// read. Configuration writes go through the plain write port; the user must
// make them only while the pool is idle, which the block does not enforce.
module fixed_block_buffer_pool
    import fbbp_pkg::*;
#(
    parameter int NUM_BLOCKS      = 256,
    parameter int MIN_FRAME_BYTES = 1514
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [7:0] block_index, [23:8] extra_reserve
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] func
    input  logic [S_TUSER_W-1:0] s_axis_tuser,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] given_index, [39:8] payload_address, [55:40] payload_length,
    // [64:56] free_count, [73:65] used_count, [82:74] peak_used,
    // [114:83] fail_count, [119:115] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // [0] ok
    output logic [M_TUSER_W-1:0] m_axis_tuser
);

    localparam int BLOCK_LIMIT = (NUM_BLOCKS < INDEX_SPAN) ? NUM_BLOCKS : INDEX_SPAN;
    localparam int AW          = $clog2(BLOCK_LIMIT);
    localparam logic [12:0] NB_LIM   = 13'(NUM_BLOCKS);
    localparam logic [CNT_W-1:0] BL_LIM  = CNT_W'(BLOCK_LIMIT);
    localparam logic [CNT_W-1:0] MIN_BLK = CNT_W'(MIN_BLOCKS);
    localparam logic [17:0] MIN_FRAME = 18'(MIN_FRAME_BYTES);

    // configuration registers
    logic [31:0] r_base_address;
    logic [8:0]  r_block_count;
    logic [15:0] r_block_size;
    logic [7:0]  r_header_size;
    logic [7:0]  r_fixed_reserve;

    // pool state
    logic [IDX_W-1:0]  r_head, n_head;
    logic [IDX_W-1:0]  r_head_link, n_head_link;
    logic              r_nonempty, n_nonempty;
    logic [CNT_W-1:0]  r_fresh, n_fresh;
    logic [CNT_W-1:0]  r_free, n_free;
    logic [CNT_W-1:0]  r_used, n_used;
    logic [CNT_W-1:0]  r_peak, n_peak;
    logic [FAIL_W-1:0] r_fail, n_fail;
    logic              r_fetch, n_fetch;

    // input and output stages
    logic                 r_in_valid;
    logic [S_TDATA_W-1:0] r_in_tdata;
    logic [S_TUSER_W-1:0] r_in_tuser;
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_tdata, n_out_tdata;
    logic [M_TUSER_W-1:0] r_out_tuser, n_out_tuser;

    logic             w_adv;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [IDX_W-1:0] w_rdata;

    assign w_adv         = r_in_valid && !r_fetch && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;

    // link RAM: read address always the cached link of the list top, so the
    // data after a pop is the link of the new top
    fbbp_ram #(
        .WIDTH (IDX_W),
        .DEPTH (BLOCK_LIMIT)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_head),
        .i_raddr (r_head_link[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        logic [IDX_W-1:0]   bidx;
        logic [EXTRA_W-1:0] extra;
        logic [IDX_W-1:0]   idx;
        logic [16:0]        skip;
        logic [23:0]        prod;
        logic [ADDR_W-1:0]  addr;
        logic [LEN_W-1:0]   len;
        logic               ok;
        logic [CNT_W-1:0]   used_new;
        logic [CNT_W-1:0]   fresh_new;
        logic [17:0]        need;

        bidx  = r_in_tdata[7:0];
        extra = r_in_tdata[23:8];

        n_head      = r_head;
        n_head_link = (r_fetch) ? w_rdata : r_head_link;
        n_nonempty  = r_nonempty;
        n_fresh     = r_fresh;
        n_free      = r_free;
        n_used      = r_used;
        n_peak      = r_peak;
        n_fail      = r_fail;
        n_fetch     = 1'b0;
        w_we        = 1'b0;
        w_waddr     = bidx[AW-1:0];

        idx       = '0;
        addr      = '0;
        len       = '0;
        ok        = 1'b0;
        skip      = 17'(r_header_size) + 17'(r_fixed_reserve) + 17'(extra);
        prod      = '0;
        used_new  = r_used + 1'b1;
        fresh_new = r_fresh;
        need      = 18'(r_header_size) + 18'(r_fixed_reserve) + MIN_FRAME;

        if (w_adv) begin
            case (t_func'(r_in_tuser))
                FUNC_ALLOC: begin
                    if (r_free == '0) begin
                        n_fail = r_fail + 1'b1;
                    end else begin
                        ok = 1'b1;
                        if (r_nonempty) begin
                            idx     = r_head;
                            n_head  = r_head_link;
                            n_fetch = 1'b1;
                        end else begin
                            idx       = r_fresh[IDX_W-1:0];
                            fresh_new = r_fresh + 1'b1;
                        end
                        n_fresh    = fresh_new;
                        n_free     = r_free - 1'b1;
                        n_used     = used_new;
                        n_peak     = (used_new > r_peak) ? used_new : r_peak;
                        n_nonempty = fresh_new > used_new;
                        prod       = idx * r_block_size;
                        addr       = r_base_address + 32'(prod) + 32'(skip);
                        len        = (17'(r_block_size) > skip)
                                   ? LEN_W'(17'(r_block_size) - skip) : '0;
                    end
                end
                FUNC_FREE: begin
                    if (!(9'(bidx) >= r_fresh || r_used == '0 ||
                          13'(bidx) >= NB_LIM)) begin
                        ok          = 1'b1;
                        w_we        = 1'b1;
                        n_head_link = r_head;
                        n_head      = bidx;
                        n_nonempty  = 1'b1;
                        n_free      = r_free + 1'b1;
                        n_used      = r_used - 1'b1;
                    end
                end
                FUNC_REBUILD: begin
                    if (!(r_block_count < MIN_BLK || r_block_count > BL_LIM ||
                          18'(r_block_size) < need)) begin
                        ok         = 1'b1;
                        n_head     = '0;
                        n_nonempty = 1'b0;
                        n_fresh    = '0;
                        n_free     = r_block_count;
                        n_used     = '0;
                        n_peak     = '0;
                        n_fail     = '0;
                    end
                end
                default: begin
                    ok = 1'b0;
                end
            endcase
        end

        n_out_tuser = ok;
        n_out_tdata = {5'd0, n_fail, n_peak, n_used, n_free, len, addr, idx};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_address  <= RST_BASE_ADDRESS;
            r_block_count   <= RST_BLOCK_COUNT;
            r_block_size    <= RST_BLOCK_SIZE;
            r_header_size   <= RST_HEADER_SIZE;
            r_fixed_reserve <= RST_FIXED_RESERVE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BASE_ADDRESS:  r_base_address  <= i_cfg_wdata;
                CFG_BLOCK_COUNT:   r_block_count   <= i_cfg_wdata[8:0];
                CFG_BLOCK_SIZE:    r_block_size    <= i_cfg_wdata[15:0];
                CFG_HEADER_SIZE:   r_header_size   <= i_cfg_wdata[7:0];
                CFG_FIXED_RESERVE: r_fixed_reserve <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_head_link <= '0;
            r_nonempty  <= 1'b0;
            r_fresh     <= '0;
            r_free      <= BL_LIM;
            r_used      <= '0;
            r_peak      <= '0;
            r_fail      <= '0;
            r_fetch     <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_head_link <= n_head_link;
            r_nonempty  <= n_nonempty;
            r_fresh     <= n_fresh;
            r_free      <= n_free;
            r_used      <= n_used;
            r_peak      <= n_peak;
            r_fail      <= n_fail;
            r_fetch     <= n_fetch;
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_tdata <= s_axis_tdata;
            r_in_tuser <= s_axis_tuser;
        end
        if (w_adv) begin
            r_out_tdata <= n_out_tdata;
            r_out_tuser <= n_out_tuser;
        end
    end

endmodule

@@ tb/tb_fixed_block_buffer_pool.sv @@
// ----------------------------------------------------------------------------
// tb_fixed_block_buffer_pool
// Self-checking testbench of the fixed block buffer pool.
// ----------------------------------------------------------------------------
// A shadow pool (LIFO free list, fresh-block cursor, counters and register
// copies) predicts every result at the moment the operation transfer is taken.
// Results are compared field by field, in order, against the predicted ones.
// A short directed part covers the special cases; a long random part then
// rebuilds the pool under many geometries and runs alloc/free traffic on it,
// with random gaps on the sender side and random stalls on the receiver side.
// ----------------------------------------------------------------------------
module tb_fixed_block_buffer_pool;
    timeunit 1ns;
    timeprecision 1ps;
    import fbbp_pkg::*;

    localparam int POOL_BLOCKS  = 256;
    localparam int FRAME_MIN    = 1514;
    localparam int STALL_MAX    = 18;
    localparam int PHASES       = 14;
    localparam int PHASE_ITEMS  = 125;
    localparam int RUN_LIMIT_NS = 8_000_000;

    typedef struct packed {
        logic        ok;
        logic [7:0]  index;
        logic [31:0] address;
        logic [15:0] length;
        logic [8:0]  free_n;
        logic [8:0]  used_n;
        logic [8:0]  peak_n;
        logic [31:0] fails;
    } t_pool_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [2:0]           i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [S_TUSER_W-1:0] s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    // register copies
    logic [31:0] cfg_base;
    logic [8:0]  cfg_count;
    logic [15:0] cfg_size;
    logic [7:0]  cfg_header;
    logic [7:0]  cfg_reserve;

    // shadow pool
    logic [7:0]  link_mem [0:POOL_BLOCKS-1];
    logic [7:0]  list_top;
    logic        list_live;
    logic [8:0]  fresh_n;
    logic [8:0]  free_n;
    logic [8:0]  used_n;
    logic [8:0]  peak_n;
    logic [31:0] fails_n;

    t_pool_result pending_results[$];
    logic [7:0]   held_blocks[$];
    int           mismatches = 0;
    int           idle_pct   = 0;
    int           stall_pct  = 0;

    fixed_block_buffer_pool #(
        .NUM_BLOCKS      (POOL_BLOCKS),
        .MIN_FRAME_BYTES (FRAME_MIN)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILED: results differ");
        $finish;
    end

    // receiver: random stall bursts, each started with a chance of stall_pct percent
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, STALL_MAX - 1)) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_pool_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing pending");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("ok",              32'(want.ok),
                            32'(m_axis_tuser[0]));
                check_field("given_index",     32'(want.index),
                            32'(m_axis_tdata[7:0]));
                check_field("payload_address", want.address, m_axis_tdata[39:8]);
                check_field("payload_length",  32'(want.length),
                            32'(m_axis_tdata[55:40]));
                check_field("free_count",      32'(want.free_n),
                            32'(m_axis_tdata[64:56]));
                check_field("used_count",      32'(want.used_n),
                            32'(m_axis_tdata[73:65]));
                check_field("peak_used",       32'(want.peak_n),
                            32'(m_axis_tdata[82:74]));
                check_field("fail_count",      want.fails,   m_axis_tdata[114:83]);
            end
        end
    end

    // Applies one operation to the shadow pool and queues the result it gives.
    task automatic pool_predict(input t_func op, input logic [7:0] bidx,
                                input logic [15:0] extra);
        t_pool_result r;
        logic [7:0]   idx;
        logic [31:0]  skip;
        r = '0;
        case (op)
            FUNC_ALLOC: begin
                if (free_n == 0) begin
                    fails_n = fails_n + 32'd1;
                end else begin
                    if (list_live) begin
                        idx      = list_top;
                        list_top = link_mem[idx];
                    end else begin
                        idx     = fresh_n[7:0];
                        fresh_n = fresh_n + 9'd1;
                    end
                    free_n = free_n - 9'd1;
                    used_n = used_n + 9'd1;
                    if (used_n > peak_n) peak_n = used_n;
                    list_live = fresh_n > used_n;
                    skip      = 32'(cfg_header) + 32'(cfg_reserve) + 32'(extra);
                    r.ok      = 1'b1;
                    r.index   = idx;
                    r.address = cfg_base + 32'(idx) * 32'(cfg_size) + skip;
                    r.length  = (32'(cfg_size) > skip) ? cfg_size - skip[15:0] : 16'd0;
                    held_blocks.push_back(idx);
                end
            end
            FUNC_FREE: begin
                if ({1'b0, bidx} < fresh_n && used_n != 0) begin
                    link_mem[bidx] = list_top;
                    list_top       = bidx;
                    list_live      = 1'b1;
                    free_n         = free_n + 9'd1;
                    used_n         = used_n - 9'd1;
                    r.ok           = 1'b1;
                end
            end
            FUNC_REBUILD: begin
                if (cfg_count >= MIN_BLOCKS && cfg_count <= POOL_BLOCKS &&
                    32'(cfg_size) >= 32'(cfg_header) + 32'(cfg_reserve) + FRAME_MIN) begin
                    list_top  = 8'd0;
                    list_live = 1'b0;
                    fresh_n   = 9'd0;
                    free_n    = cfg_count;
                    used_n    = 9'd0;
                    peak_n    = 9'd0;
                    fails_n   = 32'd0;
                    r.ok      = 1'b1;
                    held_blocks.delete();
                end
            end
            default: ;
        endcase
        r.free_n = free_n;
        r.used_n = used_n;
        r.peak_n = peak_n;
        r.fails  = fails_n;
        pending_results.push_back(r);
    endtask

    // Valid stays high after the transfer; release_bus, or a next call that waits a gap, lowers it.
    task automatic send_item(input t_func op, input logic [7:0] bidx,
                             input logic [15:0] extra);
        int gap;
        gap = 0;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            gap = $urandom_range(1, STALL_MAX);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {extra, bidx};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        pool_predict(op, bidx, extra);
    endtask

    task automatic release_bus();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // every item answers, so an empty queue plus a short margin means idle
    task automatic settle();
        release_bus();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        case (idx)
            CFG_BASE_ADDRESS:  cfg_base    = value;
            CFG_BLOCK_COUNT:   cfg_count   = value[8:0];
            CFG_BLOCK_SIZE:    cfg_size    = value[15:0];
            CFG_HEADER_SIZE:   cfg_header  = value[7:0];
            CFG_FIXED_RESERVE: cfg_reserve = value[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] base, input logic [8:0] count,
                             input logic [15:0] size, input logic [7:0] hdr,
                             input logic [7:0] res);
        settle();
        write_reg(CFG_BASE_ADDRESS,  base);
        write_reg(CFG_BLOCK_COUNT,   32'(count));
        write_reg(CFG_BLOCK_SIZE,    32'(size));
        write_reg(CFG_HEADER_SIZE,   32'(hdr));
        write_reg(CFG_FIXED_RESERVE, 32'(res));
    endtask

    // Pool as it comes out of reset: fresh blocks, list pops, bad free, nop.
    task automatic test_after_reset();
        idle_pct  = 25;
        stall_pct = 10;
        send_item(FUNC_ALLOC, 8'd0, 16'd0);
        send_item(FUNC_FREE, 8'd0, 16'd0);
        send_item(FUNC_ALLOC, 8'd0, 16'hFFFF);
        send_item(FUNC_ALLOC, 8'd0, 16'd100);
        send_item(FUNC_NOP, 8'hFF, 16'hFFFF);
        send_item(FUNC_FREE, 8'hFF, 16'd0);
        idle_pct = 0;
        send_item(FUNC_FREE, 8'd1, 16'd0);
        send_item(FUNC_FREE, 8'd0, 16'd0);
        // back-to-back pops need the link of the new top
        send_item(FUNC_ALLOC, 8'd0, 16'd0);
        send_item(FUNC_ALLOC, 8'd0, 16'd0);
    endtask

    task automatic test_bad_rebuild();
        idle_pct = 20;
        configure(RST_BASE_ADDRESS, 9'd1, RST_BLOCK_SIZE, RST_HEADER_SIZE,
                  RST_FIXED_RESERVE);
        send_item(FUNC_REBUILD, 8'd0, 16'd0);
        configure(RST_BASE_ADDRESS, 9'd300, RST_BLOCK_SIZE, RST_HEADER_SIZE,
                  RST_FIXED_RESERVE);
        send_item(FUNC_REBUILD, 8'd0, 16'd0);
        // one byte short of a full frame
        configure(RST_BASE_ADDRESS, 9'd2, 16'(32 + 6 + FRAME_MIN - 1), 8'd32, 8'd6);
        send_item(FUNC_REBUILD, 8'd0, 16'd0);
        configure(RST_BASE_ADDRESS, 9'd2, 16'(32 + 6 + FRAME_MIN), 8'd32, 8'd6);
        send_item(FUNC_REBUILD, 8'd0, 16'd0);
        configure(32'hFFFF_FFF0, 9'd2, 16'hFFFF, 8'hFF, 8'hFF);
        send_item(FUNC_REBUILD, 8'd0, 16'd0);
    endtask

    // Two-block pool: saturated length, address wrap, exhaustion, double free.
    task automatic test_empty_pool();
        send_item(FUNC_ALLOC, 8'd0, 16'hFFFF);
        send_item(FUNC_ALLOC, 8'd0, 16'd0);
        send_item(FUNC_ALLOC, 8'd0, 16'd0);
        send_item(FUNC_ALLOC, 8'd0, 16'd0);
        send_item(FUNC_FREE, 8'd1, 16'd0);
        send_item(FUNC_FREE, 8'd1, 16'd0);
        send_item(FUNC_FREE, 8'd0, 16'd0);
        send_item(FUNC_ALLOC, 8'd0, 16'd7);
        send_item(FUNC_ALLOC, 8'd0, 16'd0);
        send_item(FUNC_ALLOC, 8'd0, 16'd0);
    endtask

    // a new block count only counts after the next rebuild
    task automatic test_deferred_count();
        settle();
        write_reg(CFG_BLOCK_COUNT, 32'd3);
        send_item(FUNC_ALLOC, 8'd0, 16'd0);
        send_item(FUNC_REBUILD, 8'd0, 16'd0);
        send_item(FUNC_ALLOC, 8'd0, 16'd0);
    endtask

    task automatic test_random_traffic();
        logic [31:0] base;
        logic [8:0]  count;
        logic [15:0] size;
        logic [7:0]  hdr;
        logic [7:0]  res;
        logic [15:0] extra;
        logic [7:0]  bidx;
        int          need;
        int          alloc_pct;
        int          roll;
        int          pick;
        for (int phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0:       base = 32'd0;
                1:       base = 32'hFFFF_FFFF;
                default: base = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0:       count = 9'd2;
                1:       count = 9'(POOL_BLOCKS);
                2:       count = 9'($urandom_range(2, 12));
                default: count = 9'($urandom_range(2, POOL_BLOCKS));
            endcase
            case ($urandom_range(0, 2))
                0:       hdr = 8'd0;
                1:       hdr = 8'hFF;
                default: hdr = 8'($urandom);
            endcase
            case ($urandom_range(0, 2))
                0:       res = 8'd0;
                1:       res = 8'hFF;
                default: res = 8'($urandom);
            endcase
            need = int'(hdr) + int'(res) + FRAME_MIN;
            case ($urandom_range(0, 9))
                0:       size = 16'(need);
                1:       size = 16'hFFFF;
                2:       size = 16'($urandom_range(0, need - 1));
                default: size = 16'($urandom_range(need, 65535));
            endcase
            case ($urandom_range(0, 2))
                0:       alloc_pct = 40;
                1:       alloc_pct = 60;
                default: alloc_pct = 85;
            endcase
            if (phase >= PHASES - 2) begin
                idle_pct  = 0;
                stall_pct = 0;
            end else begin
                idle_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 20);
            end
            configure(base, count, size, hdr, res);
            send_item(FUNC_REBUILD, 8'd0, 16'd0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(0, 5))
                    0:       extra = 16'd0;
                    1:       extra = 16'hFFFF;
                    2:       extra = 16'($urandom);
                    default: extra = 16'($urandom_range(0, 600));
                endcase
                roll = $urandom_range(0, 99);
                if (roll < alloc_pct) begin
                    send_item(FUNC_ALLOC, 8'($urandom), extra);
                end else if (roll < 92) begin
                    if (held_blocks.size() != 0) begin
                        pick = $urandom_range(0, held_blocks.size() - 1);
                        bidx = held_blocks[pick];
                        held_blocks.delete(pick);
                    end else begin
                        bidx = 8'($urandom);
                    end
                    send_item(FUNC_FREE, bidx, extra);
                end else begin
                    case ($urandom_range(0, 3))
                        0: send_item(FUNC_NOP, 8'($urandom), extra);
                        1: send_item(FUNC_REBUILD, 8'($urandom), extra);
                        2: send_item(FUNC_FREE, 8'($urandom), extra);
                        default: begin
                            // may hit a block that is already free
                            bidx = (fresh_n != 0) ? 8'($urandom_range(0, fresh_n - 1))
                                                  : 8'd0;
                            send_item(FUNC_FREE, bidx, extra);
                        end
                    endcase
                end
                if ($urandom_range(0, 199) == 0) settle();
            end
        end
    endtask

    task automatic finish_run();
        idle_pct  = 0;
        stall_pct = 0;
        release_bus();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_BASE_ADDRESS;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_NOP;
        cfg_base      = RST_BASE_ADDRESS;
        cfg_count     = RST_BLOCK_COUNT;
        cfg_size      = RST_BLOCK_SIZE;
        cfg_header    = RST_HEADER_SIZE;
        cfg_reserve   = RST_FIXED_RESERVE;
        list_top      = 8'd0;
        list_live     = 1'b0;
        fresh_n       = 9'd0;
        free_n        = 9'(POOL_BLOCKS);
        used_n        = 9'd0;
        peak_n        = 9'd0;
        fails_n       = 32'd0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_after_reset();
        test_bad_rebuild();
        test_empty_pool();
        test_deferred_count();
        test_random_traffic();
        finish_run();
    end

endmodule
